[rtl/core/stb_pkg.sv]
// Shared types and codes for the software timer bank.
// Command/status structs join the controller and the datapath.
// No dependencies.
package stb_pkg;

  // input mode codes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_CREATE  = 3'd1;
  localparam logic [2:0] MODE_START   = 3'd2;
  localparam logic [2:0] MODE_CHANGE  = 3'd3;
  localparam logic [2:0] MODE_STOP    = 3'd4;
  localparam logic [2:0] MODE_DELETE  = 3'd5;
  localparam logic [2:0] MODE_QUERY   = 3'd6;
  localparam logic [2:0] MODE_UNKNOWN = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_FAILED  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD_RD,
    ST_CMD_EV,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_END
  } stb_state_t;

  typedef struct packed {
    logic accept;    // latch the input item, clear the sweep
    logic tick_step; // commit one slot of the tick sweep
    logic cmd_exec;  // commit a command and post its result
    logic flush;     // post the held expiry as the final result
  } stb_cmd_t;

  typedef struct packed {
    logic in_tick;    // mode on the input port is a tick
    logic out_free;   // output register can take a result this cycle
    logic tick_push;  // current slot expires while an expiry is already held
    logic sweep_end;  // sweep is at the last slot
    logic pend_valid; // an expiry is held back awaiting its last flag
  } stb_status_t;

endpackage

[rtl/core/stb_ctrl.sv]
// Controller for the software timer bank: sequences commands and tick sweeps.
// Depends on stb_pkg; drives stb_dp through stb_cmd_t.
module stb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  stb_pkg::stb_status_t st,
  output stb_pkg::stb_cmd_t    cmd
);
  import stb_pkg::*;

  stb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = st.in_tick ? ST_TICK_RD : ST_CMD_RD;
      end
      ST_CMD_RD:  state_next = ST_CMD_EV;
      ST_CMD_EV: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      ST_TICK_RD: state_next = ST_TICK_EV;
      ST_TICK_EV: begin
        if (!st.tick_push || st.out_free)
          state_next = st.sweep_end ? ST_TICK_END : ST_TICK_RD;
      end
      ST_TICK_END: begin
        if (!st.pend_valid || st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_CMD_EV:   cmd.cmd_exec  = st.out_free;
      ST_TICK_EV:  cmd.tick_step = !st.tick_push || st.out_free;
      ST_TICK_END: cmd.flush     = st.pend_valid && st.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/core/stb_dp.sv]
// Datapath for the software timer bank: slot flags, period and countdown
// memories, tick sweep counter, held expiry and output register.
// Depends on stb_pkg; controlled by stb_ctrl.
module stb_dp #(
  parameter int NUM_SLOTS   = 8,
  parameter int PERIOD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stb_pkg::stb_cmd_t    cmd,
  output stb_pkg::stb_status_t st,
  input  logic [2:0]           mode,
  input  logic [2:0]           timer_index,
  input  logic [31:0]          period_value,
  input  logic                 repeat_flag,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           result_kind,
  output logic [2:0]           slot_out,
  output logic                 running_flag,
  output logic                 last
);
  import stb_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW     = PERIOD_BITS;

  function automatic logic [SLOT_W-1:0] first_free(input logic [NUM_SLOTS-1:0] u);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!u[i]) r = SLOT_W'(i);
    end
    return r;
  endfunction

  logic [NUM_SLOTS-1:0] slot_used, running, repeating;
  logic [PW-1:0]        per_mem [NUM_SLOTS];
  logic [PW-1:0]        cd_mem  [NUM_SLOTS];
  logic [PW-1:0]        per_rd, cd_rd;

  // latched item
  logic [2:0]    mode_lat;
  logic [2:0]    idx_lat;
  logic [PW-1:0] per_lat;
  logic          rep_lat;

  logic [SLOT_W-1:0] sweep;
  logic              pend_valid;
  logic [2:0]        pend_slot;
  logic              pend_run;

  logic [SLOT_W-1:0] slot_a, rd_a, free_a;
  logic              in_range, idx_ok, bank_full, expire, sweep_end, out_free;

  // command result and write controls
  logic [1:0]    ex_kind;
  logic [2:0]    ex_slot;
  logic          ex_run, create_ok, cmd_ok;
  logic [PW-1:0] new_per;
  logic          cd_we, per_we;
  logic [SLOT_W-1:0] cd_wa, per_wa;
  logic [PW-1:0] cd_wd, per_wd;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_lat <= mode;
      idx_lat  <= timer_index;
      per_lat  <= period_value[PW-1:0];
      rep_lat  <= repeat_flag;
    end
  end

  assign slot_a    = SLOT_W'(idx_lat);
  assign in_range  = 32'(idx_lat) < NUM_SLOTS;
  assign idx_ok    = in_range && slot_used[slot_a] && (mode_lat != MODE_UNKNOWN);
  assign bank_full = &slot_used;
  assign free_a    = first_free(slot_used);
  assign create_ok = !bank_full && (per_lat != '0);
  assign sweep_end = sweep == SLOT_W'(NUM_SLOTS - 1);
  assign expire    = running[sweep] && (cd_rd <= PW'(1));
  assign out_free  = !out_valid || !out_stall;
  assign rd_a      = (mode_lat == MODE_TICK) ? sweep : slot_a;
  // start reloads the stored period; change takes a nonzero new one
  assign new_per   = (mode_lat == MODE_CHANGE && per_lat != '0) ? per_lat : per_rd;

  always_comb begin
    st.in_tick    = mode == MODE_TICK;
    st.out_free   = out_free;
    st.tick_push  = expire && pend_valid;
    st.sweep_end  = sweep_end;
    st.pend_valid = pend_valid;
  end

  // command outcome
  always_comb begin
    ex_kind = KIND_FAILED;
    ex_slot = idx_lat;
    ex_run  = 1'b0;
    cmd_ok  = 1'b0;
    if (mode_lat == MODE_CREATE) begin
      ex_slot = '0;
      if (create_ok) begin
        ex_kind = KIND_DONE;
        ex_slot = 3'(free_a);
      end
    end else if (idx_ok) begin
      cmd_ok  = 1'b1;
      ex_kind = KIND_DONE;
      case (mode_lat)
        MODE_START, MODE_CHANGE: ex_run = 1'b1;
        MODE_QUERY:              ex_run = running[slot_a];
        default:                 ex_run = 1'b0;
      endcase
    end
  end

  // memory write controls
  always_comb begin
    cd_we  = 1'b0;
    cd_wa  = sweep;
    cd_wd  = cd_rd - PW'(1);
    per_we = 1'b0;
    per_wa = slot_a;
    per_wd = per_lat;
    if (cmd.tick_step && running[sweep]) begin
      cd_we = 1'b1;
      if (expire) cd_wd = repeating[sweep] ? per_rd : '0;
    end
    if (cmd.cmd_exec) begin
      if (mode_lat == MODE_CREATE && create_ok) begin
        per_we = 1'b1;
        per_wa = free_a;
      end
      if (cmd_ok && (mode_lat == MODE_START || mode_lat == MODE_CHANGE)) begin
        cd_we  = 1'b1;
        cd_wa  = slot_a;
        cd_wd  = new_per;
        per_we = (mode_lat == MODE_CHANGE) && (per_lat != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cd_we)  cd_mem[cd_wa]   <= cd_wd;
    if (per_we) per_mem[per_wa] <= per_wd;
    cd_rd  <= cd_mem[rd_a];
    per_rd <= per_mem[rd_a];
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      running   <= '0;
      repeating <= '0;
    end else begin
      if (cmd.tick_step && expire) running[sweep] <= repeating[sweep];
      if (cmd.cmd_exec) begin
        if (mode_lat == MODE_CREATE) begin
          if (create_ok) begin
            slot_used[free_a] <= 1'b1;
            running[free_a]   <= 1'b0;
            repeating[free_a] <= rep_lat;
          end
        end else if (cmd_ok) begin
          case (mode_lat)
            MODE_START, MODE_CHANGE: running[slot_a] <= 1'b1;
            MODE_STOP:               running[slot_a] <= 1'b0;
            MODE_DELETE: begin
              running[slot_a]   <= 1'b0;
              slot_used[slot_a] <= 1'b0;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // sweep counter and held expiry (last flag is known only once the next
  // expiry or the end of the sweep is seen)
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        sweep      <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.tick_step) begin
        if (!sweep_end) sweep <= sweep + SLOT_W'(1);
        if (expire) pend_valid <= 1'b1;
      end
      if (cmd.flush) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_step && expire) begin
      pend_slot <= 3'(sweep);
      pend_run  <= repeating[sweep];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.cmd_exec || cmd.flush || (cmd.tick_step && expire && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_exec) begin
      result_kind  <= ex_kind;
      slot_out     <= ex_slot;
      running_flag <= ex_run;
      last         <= 1'b1;
    end else if (cmd.flush || (cmd.tick_step && expire && pend_valid)) begin
      result_kind  <= KIND_EXPIRED;
      slot_out     <= pend_slot;
      running_flag <= pend_run;
      last         <= cmd.flush;
    end
  end

endmodule

[rtl/core/software_timer_bank_top.sv]
// Software timer bank. Commands: after accept, a memory read state, then an
// execute state that writes the result to the output register and returns
// to idle. Tick: one memory read state and one update state per slot, then
// one closing state, one expiry result per expiring slot; any item takes
// longer while the output is stalled. One item at a time.
// Synchronous reset clears all slot flags; period and countdown memories are
// written before use.
module software_timer_bank_top #(
  parameter int NUM_SLOTS   = 8,
  parameter int PERIOD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [2:0]  timer_index,
  input  logic [31:0] period_value,
  input  logic        repeat_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [2:0]  slot_out,
  output logic        running_flag,
  output logic        last
);
  import stb_pkg::*;

  stb_cmd_t    cmd;
  stb_status_t st;

  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  stb_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .mode         (mode),
    .timer_index  (timer_index),
    .period_value (period_value),
    .repeat_flag  (repeat_flag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .slot_out     (slot_out),
    .running_flag (running_flag),
    .last         (last)
  );

endmodule

[rtl/core/software_timer_bank_chk.sv]
// Port-level checks for the software timer bank, bound to the top level.
// Depends on stb_pkg.
module software_timer_bank_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] result_kind,
  input logic [2:0] slot_out,
  input logic       running_flag,
  input logic       last
);
  import stb_pkg::*;

  // block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind != 2'd3)
    else $error("illegal result kind");

  // a command answers with exactly one result
  a_cmd_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_EXPIRED |-> last)
    else $error("command result without last");

  a_fail_not_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_FAILED |-> !running_flag)
    else $error("failed result shows running");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(slot_out)
      && $stable(running_flag) && $stable(last))
    else $error("stalled result changed");

endmodule

bind software_timer_bank_top software_timer_bank_chk u_chk (.*);
